// ----- sv/pmsb_pkg.sv -----
// Shared types and constants of the page mode sprite blitter.
package pmsb_pkg;

	localparam int DEF_SCREEN_COLUMNS = 84;
	localparam int DEF_SCREEN_ROWS    = 48;
	localparam int DEF_STORE_BYTES    = 504;

	// Width of the internal address arithmetic; holds page * columns + column for the default screen size.
	localparam int WIDE_W = 16;

	typedef enum logic [1:0] {
		ACT_DRAW  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		WSEL_CLEAR   = 2'd0,
		WSEL_PIX     = 2'd1,
		WSEL_MERGE_A = 2'd2,
		WSEL_MERGE_B = 2'd3
	} wsel_t;

	typedef enum logic {
		RSEL_A = 1'b0,
		RSEL_B = 1'b1
	} rsel_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] sprite_x;
		logic [7:0] sprite_y;
		logic [7:0] col_index;
		logic [4:0] page_index;
		logic [7:0] sprite_width;
		logic [7:0] sprite_height;
		logic       visible;
		logic [7:0] pixel_byte;
	} item_t;

	typedef struct packed {
		logic  accept;
		logic  we;
		wsel_t wsel;
		logic  re;
		rsel_t rsel;
		logic  load_rd;
		logic  load_out;
		logic  clr_step;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    draw_ok;
		logic    aligned;
		logic    read_ok;
		logic    rd_en_q;
		logic    spill_q;
		logic    clr_last;
	} dp_status_t;

endpackage

// ----- sv/pmsb_ifs.sv -----
// Valid/ready channel interfaces for draw items and result items.
interface pmsb_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] sprite_x;
	logic [7:0] sprite_y;
	logic [7:0] col_index;
	logic [4:0] page_index;
	logic [7:0] sprite_width;
	logic [7:0] sprite_height;
	logic       visible;
	logic [7:0] pixel_byte;

	modport source (
		output valid, action, sprite_x, sprite_y, col_index, page_index,
			sprite_width, sprite_height, visible, pixel_byte,
		input ready
	);
	modport sink (
		input valid, action, sprite_x, sprite_y, col_index, page_index,
			sprite_width, sprite_height, visible, pixel_byte,
		output ready
	);
endinterface

interface pmsb_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       wrote;

	modport source (output valid, read_byte, wrote, input ready);
	modport sink (input valid, read_byte, wrote, output ready);
endinterface

// ----- sv/page_mode_sprite_blitter.sv -----
// Top level of the page mode sprite blitter: monochrome page framebuffer with sprite byte draws.
// The block takes one item at a time and returns exactly one result transfer for each one. A
// dropped draw, an unused action or a read outside the store goes straight to its result; a
// page aligned draw writes its byte, an unaligned draw reads and merges its byte and, when the
// spill into the page below lies in the store, that byte too, a read inside the store reads
// its byte and a clear writes every byte. This follows from the single frame store RAM, which
// has one write port and one registered read port, so each unaligned draw is a read, merge and
// write per touched byte and a clear writes one byte per cycle. After reset the block zeroes
// the frame store before it accepts the first item. A finished result waits in an output
// register while the next item runs, and an item that finishes while that register is still
// full waits for it.
module page_mode_sprite_blitter import pmsb_pkg::*; #(
	parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
	parameter int STORE_BYTES    = DEF_STORE_BYTES
) (
	input logic          clk,
	input logic          arst_n,
	pmsb_item_if.sink    item,
	pmsb_result_if.source result
);

	item_t      payload;
	dp_cmd_t    cmd;
	dp_status_t sts;

	always_comb begin
		payload.action        = item.action;
		payload.sprite_x      = item.sprite_x;
		payload.sprite_y      = item.sprite_y;
		payload.col_index     = item.col_index;
		payload.page_index    = item.page_index;
		payload.sprite_width  = item.sprite_width;
		payload.sprite_height = item.sprite_height;
		payload.visible       = item.visible;
		payload.pixel_byte    = item.pixel_byte;
	end

	pmsb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	pmsb_datapath #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS),
		.STORE_BYTES   (STORE_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (payload),
		.cmd      (cmd),
		.sts      (sts),
		.read_byte(result.read_byte),
		.wrote    (result.wrote)
	);

endmodule

// ----- sv/pmsb_ram.sv -----
// Generic simple dual port RAM with one write port and a registered read port.
module pmsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 504
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/pmsb_datapath.sv -----
// Address decode, clipping checks, merge logic, clear pointer and frame store of the blitter.
module pmsb_datapath import pmsb_pkg::*; #(
	parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
	parameter int STORE_BYTES    = DEF_STORE_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  dp_cmd_t    cmd,
	output dp_status_t sts,
	output logic [7:0] read_byte,
	output logic       wrote
);

	localparam int ADDR_W = $clog2(STORE_BYTES);

	logic [5:0]        pages;
	logic [5:0]        draw_page;
	logic [8:0]        draw_col;
	logic [5:0]        sel_page;
	logic [8:0]        sel_col;
	logic [WIDE_W-1:0] addr_a_wide;
	logic [WIDE_W-1:0] addr_b_wide;
	logic              is_read;
	logic              col_ok;
	logic              a_ok;
	logic              b_ok;
	logic              draw_ok;
	logic              read_ok;

	logic [ADDR_W-1:0] addr_a_q;
	logic [ADDR_W-1:0] addr_b_q;
	logic [7:0]        pix_q;
	logic [2:0]        off_q;
	logic              spill_q;
	logic              rd_en_q;
	logic              wrote_pend_q;
	logic [7:0]        rd_q;
	logic [ADDR_W-1:0] clr_ptr_q;
	logic [7:0]        read_byte_q;
	logic              wrote_q;

	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [3:0]        spill_shift;
	logic              clr_last;

	always_comb begin
		is_read     = (action_t'(item.action) == ACT_READ);
		pages       = 6'((9'(item.sprite_height) + 9'd7) >> 3);
		draw_page   = 6'(item.sprite_y[7:3]) + 6'(item.page_index);
		draw_col    = 9'(item.sprite_x) + 9'(item.col_index);
		sel_page    = is_read ? 6'(item.page_index) : draw_page;
		sel_col     = is_read ? 9'(item.col_index) : draw_col;
		addr_a_wide = WIDE_W'(sel_page) * WIDE_W'(SCREEN_COLUMNS) + WIDE_W'(sel_col);
		addr_b_wide = addr_a_wide + WIDE_W'(SCREEN_COLUMNS);
		col_ok      = sel_col < 9'(SCREEN_COLUMNS);
		a_ok        = addr_a_wide < WIDE_W'(STORE_BYTES);
		b_ok        = addr_b_wide < WIDE_W'(STORE_BYTES);
		draw_ok     = item.visible
			&& (9'(item.sprite_x) < 9'(SCREEN_COLUMNS))
			&& (9'(item.sprite_y) < 9'(SCREEN_ROWS))
			&& (item.col_index < item.sprite_width)
			&& (6'(item.page_index) < pages)
			&& col_ok && a_ok;
		read_ok     = col_ok && a_ok;
	end

	assign clr_last = (clr_ptr_q == ADDR_W'(STORE_BYTES - 1));

	always_comb begin
		sts.action   = action_t'(item.action);
		sts.draw_ok  = draw_ok;
		sts.aligned  = (item.sprite_y[2:0] == 3'd0);
		sts.read_ok  = read_ok;
		sts.rd_en_q  = rd_en_q;
		sts.spill_q  = spill_q;
		sts.clr_last = clr_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_a_q     <= ADDR_W'(addr_a_wide);
			addr_b_q     <= ADDR_W'(addr_b_wide);
			pix_q        <= item.pixel_byte;
			off_q        <= item.sprite_y[2:0];
			spill_q      <= b_ok;
			rd_en_q      <= is_read && read_ok;
			wrote_pend_q <= (action_t'(item.action) == ACT_DRAW) && draw_ok;
		end
		if (cmd.load_rd) begin
			rd_q <= ram_rdata;
		end
		if (cmd.load_out) begin
			read_byte_q <= rd_en_q ? rd_q : 8'd0;
			wrote_q     <= wrote_pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_ptr_q <= clr_last ? '0 : clr_ptr_q + ADDR_W'(1);
		end
	end

	assign spill_shift = 4'd8 - {1'b0, off_q};

	always_comb begin
		case (cmd.wsel)
			WSEL_CLEAR: begin
				ram_waddr = clr_ptr_q;
				ram_wdata = 8'd0;
			end
			WSEL_PIX: begin
				ram_waddr = addr_a_q;
				ram_wdata = pix_q;
			end
			WSEL_MERGE_A: begin
				ram_waddr = addr_a_q;
				ram_wdata = ram_rdata | 8'(pix_q << off_q);
			end
			WSEL_MERGE_B: begin
				ram_waddr = addr_b_q;
				ram_wdata = ram_rdata | 8'(pix_q >> spill_shift);
			end
			default: begin
				ram_waddr = clr_ptr_q;
				ram_wdata = 8'd0;
			end
		endcase
	end

	assign ram_raddr = (cmd.rsel == RSEL_B) ? addr_b_q : addr_a_q;

	pmsb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign read_byte = read_byte_q;
	assign wrote     = wrote_q;

endmodule

// ----- sv/pmsb_ctrl.sv -----
// Controller state machine that sequences clears, draws and reads of the blitter.
module pmsb_ctrl import pmsb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_INIT      = 9'b000000001,
		ST_IDLE      = 9'b000000010,
		ST_CLEAR     = 9'b000000100,
		ST_WRITE_PIX = 9'b000001000,
		ST_READ_A    = 9'b000010000,
		ST_MERGE_A   = 9'b000100000,
		ST_MERGE_B   = 9'b001000000,
		ST_HOLD      = 9'b010000000,
		ST_FINISH    = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || result_ready;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.wsel     = WSEL_CLEAR;
		cmd.rsel     = RSEL_A;
		cmd.accept   = item_ready && item_valid;
		case (state_q)
			ST_INIT: begin
				cmd.we       = 1'b1;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					case (sts.action)
						ACT_DRAW: begin
							if (!sts.draw_ok) begin
								state_nxt = ST_FINISH;
							end else if (sts.aligned) begin
								state_nxt = ST_WRITE_PIX;
							end else begin
								state_nxt = ST_READ_A;
							end
						end
						ACT_CLEAR: state_nxt = ST_CLEAR;
						ACT_READ:  state_nxt = sts.read_ok ? ST_READ_A : ST_FINISH;
						default:   state_nxt = ST_FINISH;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.we       = 1'b1;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_WRITE_PIX: begin
				cmd.we    = 1'b1;
				cmd.wsel  = WSEL_PIX;
				state_nxt = ST_FINISH;
			end
			ST_READ_A: begin
				cmd.re    = 1'b1;
				state_nxt = sts.rd_en_q ? ST_HOLD : ST_MERGE_A;
			end
			ST_MERGE_A: begin
				cmd.we   = 1'b1;
				cmd.wsel = WSEL_MERGE_A;
				cmd.re   = sts.spill_q;
				cmd.rsel = RSEL_B;
				state_nxt = sts.spill_q ? ST_MERGE_B : ST_FINISH;
			end
			ST_MERGE_B: begin
				cmd.we    = 1'b1;
				cmd.wsel  = WSEL_MERGE_B;
				state_nxt = ST_FINISH;
			end
			ST_HOLD: begin
				cmd.load_rd = 1'b1;
				state_nxt   = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- verif/page_mode_sprite_blitter_tb.sv -----
// Self-checking testbench of the page mode sprite blitter with its own model of the frame store.
`timescale 1ns / 1ps

module page_mode_sprite_blitter_tb;
	import pmsb_pkg::*;

	localparam int COLS = DEF_SCREEN_COLUMNS;
	localparam int ROWS = DEF_SCREEN_ROWS;
	localparam int STORE = DEF_STORE_BYTES;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = STORE + 16;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       wrote;
	} blit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pmsb_item_if   item_ch ();
	pmsb_result_if result_ch ();

	page_mode_sprite_blitter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	logic [7:0]   frame_image [STORE];
	blit_result_t pending_results [$];
	int           err_count = 0;
	int           src_idle_pct = 0;
	int           snk_idle_pct = 0;
	int           stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic in_store(int unsigned page, int unsigned col);
		int unsigned base;
		base = page * COLS;
		if (base >= STORE)
			return 1'b0;
		return (base + col) < STORE;
	endfunction

	function automatic logic apply_draw(item_t it);
		int unsigned pages, col, page, a;
		logic [2:0]  off;
		logic [15:0] spread;
		if (!it.visible)
			return 1'b0;
		if (int'(it.sprite_x) >= COLS || int'(it.sprite_y) >= ROWS)
			return 1'b0;
		pages = (int'(it.sprite_height) + 7) / 8;
		if (it.col_index >= it.sprite_width || int'(it.page_index) >= pages)
			return 1'b0;
		col = int'(it.sprite_x) + int'(it.col_index);
		if (col >= COLS)
			return 1'b0;
		page = int'(it.sprite_y) / 8 + int'(it.page_index);
		if (!in_store(page, col))
			return 1'b0;
		off = it.sprite_y[2:0];
		a = page * COLS + col;
		if (off == 3'd0) begin
			frame_image[a] = it.pixel_byte;
		end else begin
			// The pixels pushed past the bottom of the page land in the page below.
			spread = {8'h00, it.pixel_byte} << off;
			frame_image[a] = frame_image[a] | spread[7:0];
			if (in_store(page + 1, col))
				frame_image[(page + 1) * COLS + col] =
					frame_image[(page + 1) * COLS + col] | spread[15:8];
		end
		return 1'b1;
	endfunction

	function automatic blit_result_t predict_blit(item_t it);
		blit_result_t r;
		r = '0;
		case (it.action)
			ACT_DRAW: begin
				r.wrote = apply_draw(it);
			end
			ACT_CLEAR: begin
				foreach (frame_image[i])
					frame_image[i] = 8'h00;
			end
			ACT_READ: begin
				if (int'(it.col_index) < COLS
						&& in_store(int'(it.page_index), int'(it.col_index)))
					r.read_byte = frame_image[int'(it.page_index) * COLS + int'(it.col_index)];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic item_t make_item(logic [1:0] action, int sx, int sy, int col, int page,
			int w, int h, logic vis, int pix);
		item_t it;
		it.action = action;
		it.sprite_x = 8'(sx);
		it.sprite_y = 8'(sy);
		it.col_index = 8'(col);
		it.page_index = 5'(page);
		it.sprite_width = 8'(w);
		it.sprite_height = 8'(h);
		it.visible = vis;
		it.pixel_byte = 8'(pix);
		return it;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic send_item(item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= it.action;
		item_ch.sprite_x <= it.sprite_x;
		item_ch.sprite_y <= it.sprite_y;
		item_ch.col_index <= it.col_index;
		item_ch.page_index <= it.page_index;
		item_ch.sprite_width <= it.sprite_width;
		item_ch.sprite_height <= it.sprite_height;
		item_ch.visible <= it.visible;
		item_ch.pixel_byte <= it.pixel_byte;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_results.push_back(predict_blit(it));
	endtask

	function automatic item_t random_item();
		item_t it;
		int    sel, w, h;
		sel = $urandom_range(99);
		it = make_item(ACT_DRAW, 0, 0, 0, 0, 1, 8, 1'b1, 0);
		if (sel < 1) begin
			it.action = ACT_CLEAR;
		end else if (sel < 14) begin
			it.action = ACT_READ;
			it.col_index = 8'($urandom_range(COLS - 1));
			it.page_index = 5'($urandom_range(ROWS / 8 - 1));
		end else if (sel < 22) begin
			it.action = 2'($urandom_range(3));
			it.sprite_x = 8'($urandom_range(255));
			it.sprite_y = 8'($urandom_range(255));
			it.col_index = 8'($urandom_range(255));
			it.page_index = 5'($urandom_range(31));
			it.sprite_width = 8'($urandom_range(255));
			it.sprite_height = 8'($urandom_range(255));
			it.visible = 1'($urandom_range(1));
			it.pixel_byte = 8'($urandom_range(255));
		end else begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 24);
			it.sprite_x = 8'($urandom_range(COLS - 1));
			if ($urandom_range(99) < 30)
				it.sprite_y = 8'($urandom_range(ROWS / 8 - 1) * 8);
			else
				it.sprite_y = 8'($urandom_range(ROWS - 1));
			it.sprite_width = 8'(w);
			it.sprite_height = 8'(h);
			it.col_index = 8'($urandom_range(w - 1));
			it.page_index = 5'($urandom_range((h + 7) / 8 - 1));
			it.pixel_byte = 8'($urandom_range(255));
		end
		return it;
	endfunction

	task automatic test_reset_state();
		send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0));
		send_item(make_item(ACT_READ, 0, 0, COLS - 1, ROWS / 8 - 1, 0, 0, 1'b0, 0));
	endtask

	task automatic test_aligned_draw();
		send_item(make_item(ACT_DRAW, 0, 0, 0, 0, 1, 8, 1'b1, 8'hFF));
		send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0, 0));
		send_item(make_item(ACT_DRAW, COLS - 1, 40, 0, 0, 255, 255, 1'b1, 8'hA5));
		send_item(make_item(ACT_READ, 0, 0, COLS - 1, 5, 0, 0, 1'b0, 0));
	endtask

	task automatic test_unaligned_spill();
		send_item(make_item(ACT_DRAW, 10, 3, 0, 0, 1, 8, 1'b1, 8'hFF));
		send_item(make_item(ACT_READ, 0, 0, 10, 0, 0, 0, 1'b0, 0));
		send_item(make_item(ACT_READ, 0, 0, 10, 1, 0, 0, 1'b0, 0));
		// The spill below the last page falls outside the store and is skipped.
		send_item(make_item(ACT_DRAW, 20, ROWS - 1, 0, 0, 1, 8, 1'b1, 8'h81));
		send_item(make_item(ACT_READ, 0, 0, 20, 5, 0, 0, 1'b0, 0));
	endtask

	task automatic test_drops();
		send_item(make_item(ACT_DRAW, 30, 0, 0, 0, 1, 8, 1'b0, 8'hFF));
		send_item(make_item(ACT_DRAW, COLS, 0, 0, 0, 1, 8, 1'b1, 8'hFF));
		send_item(make_item(ACT_DRAW, 255, 255, 255, 31, 255, 255, 1'b1, 8'hFF));
		send_item(make_item(ACT_DRAW, 31, ROWS, 0, 0, 1, 8, 1'b1, 8'hFF));
		send_item(make_item(ACT_DRAW, 32, 0, 0, 0, 0, 8, 1'b1, 8'hFF));
		send_item(make_item(ACT_DRAW, 33, 0, 0, 0, 1, 0, 1'b1, 8'hFF));
		send_item(make_item(ACT_DRAW, COLS - 4, 0, 4, 0, 10, 8, 1'b1, 8'hFF));
		send_item(make_item(ACT_DRAW, 34, 40, 0, 1, 1, 16, 1'b1, 8'hFF));
	endtask

	task automatic test_read_range();
		send_item(make_item(ACT_READ, 0, 0, COLS, 0, 0, 0, 1'b0, 0));
		send_item(make_item(ACT_READ, 0, 0, 0, ROWS / 8, 0, 0, 1'b0, 0));
		send_item(make_item(ACT_READ, 255, 255, 255, 31, 255, 255, 1'b1, 8'hFF));
	endtask

	task automatic test_clear_and_nop();
		send_item(make_item(ACT_NOP, 255, 255, 255, 31, 255, 255, 1'b1, 8'hFF));
		send_item(make_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0, 0));
		send_item(make_item(ACT_READ, 0, 0, 10, 0, 0, 0, 1'b0, 0));
	endtask

	task automatic test_random_traffic(int count, int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (count)
			send_item(random_item());
	endtask

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin : check_results
		blit_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (result_ch.read_byte !== want.read_byte)
					report_mismatch($sformatf("read_byte got %h expected %h",
						result_ch.read_byte, want.read_byte));
				if (result_ch.wrote !== want.wrote)
					report_mismatch($sformatf("wrote got %b expected %b",
						result_ch.wrote, want.wrote));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		foreach (frame_image[i])
			frame_image[i] = 8'h00;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_NOP;
		item_ch.sprite_x <= '0;
		item_ch.sprite_y <= '0;
		item_ch.col_index <= '0;
		item_ch.page_index <= '0;
		item_ch.sprite_width <= '0;
		item_ch.sprite_height <= '0;
		item_ch.visible <= 1'b0;
		item_ch.pixel_byte <= '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		src_idle_pct = 30;
		snk_idle_pct = 67;
		test_reset_state();
		test_aligned_draw();
		test_unaligned_spill();
		test_drops();
		test_read_range();
		test_clear_and_nop();
		test_random_traffic(410, 30, 67);
		test_random_traffic(410, 67, 30);
		test_random_traffic(410, 0, 0);
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/pmsb_pkg.sv
sv/pmsb_ifs.sv
sv/pmsb_ram.sv
sv/pmsb_datapath.sv
sv/pmsb_ctrl.sv
sv/page_mode_sprite_blitter.sv
verif/page_mode_sprite_blitter_tb.sv
